[src/gsa_pkg.sv]
// Shared widths, codes and control types for the generational slot allocator.
`default_nettype none

package gsa_pkg;

	localparam int SLOT_COUNT_DEF = 1024;

	localparam int REQ_TYPE_W     = 2;
	localparam int SLOT_INDEX_W   = 11;
	localparam int GEN_W          = 16;
	localparam int STATUS_W       = 2;
	localparam int GRANTED_SLOT_W = 10;
	localparam int RETIRED_W      = 11;

	localparam logic [GEN_W-1:0] GEN_MAX = 16'hFFFF;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_ALLOC    = 2'd0,
		REQ_FREE     = 2'd1,
		REQ_VALIDATE = 2'd2
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK            = 2'd0,
		STS_EXHAUSTED     = 2'd1,
		STS_FREE_REJECTED = 2'd2,
		STS_NOT_VALID     = 2'd3
	} status_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;  // take the input beat, launch slot table and ring reads
		logic commit;   // update state, write stores, load the output register
	} gsa_cmd_t;

endpackage

`default_nettype wire

[src/gsa_ctrl.sv]
// Request sequencer: capture/commit state machine and output valid.
`default_nettype none

module gsa_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output gsa_pkg::gsa_cmd_t     cmd
);
	import gsa_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.capture = in_valid && (state_q == ST_IDLE);
		cmd.commit  = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.commit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[src/gsa_datapath.sv]
// Slot table, recycle ring, pointers, counters and result register.
`default_nettype none

module gsa_datapath #(
	parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire gsa_pkg::gsa_cmd_t                   cmd,
	input  wire logic [gsa_pkg::REQ_TYPE_W-1:0]      req_type,
	input  wire logic [gsa_pkg::SLOT_INDEX_W-1:0]    slot_index,
	input  wire logic [gsa_pkg::GEN_W-1:0]           handle_generation,
	output logic [gsa_pkg::STATUS_W-1:0]             status,
	output logic [gsa_pkg::GRANTED_SLOT_W-1:0]       granted_slot,
	output logic [gsa_pkg::GEN_W-1:0]                granted_generation,
	output logic [gsa_pkg::RETIRED_W-1:0]            retired_total
);
	import gsa_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int CMP_W = (CNT_W > SLOT_INDEX_W) ? CNT_W : SLOT_INDEX_W;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOT_COUNT);
	localparam logic [CMP_W-1:0] CMP_FULL = CMP_W'(SLOT_COUNT);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	typedef struct packed {
		logic             live;
		logic [GEN_W-1:0] gen;
	} tbl_entry_t;

	// Ring carries the bumped generation so an allocate needs no table read.
	typedef struct packed {
		logic [IDX_W-1:0] slot;
		logic [GEN_W-1:0] gen;
	} ring_entry_t;

	tbl_entry_t  tbl_mem [SLOT_COUNT];
	ring_entry_t ring_mem [SLOT_COUNT];

	tbl_entry_t  tbl_rd_q;
	ring_entry_t ring_rd_q;

	logic [REQ_TYPE_W-1:0]   req_q;
	logic [SLOT_INDEX_W-1:0] idx_q;
	logic [GEN_W-1:0]        hgen_q;

	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q, fresh_q, retired_q;

	logic [STATUS_W-1:0]       status_q;
	logic [GRANTED_SLOT_W-1:0] gslot_q;
	logic [GEN_W-1:0]          ggen_q;
	logic [RETIRED_W-1:0]      retired_out_q;

	// Read address from the incoming beat.
	logic [CMP_W-1:0] in_idx_ext;
	logic [IDX_W-1:0] in_addr;

	assign in_idx_ext = CMP_W'(slot_index);
	assign in_addr    = in_idx_ext[IDX_W-1:0];

	// Commit-cycle decode.
	logic [CMP_W-1:0] idx_ext, fresh_ext;
	logic             in_range, seen;
	logic             entry_live;
	logic [GEN_W-1:0] entry_gen, gen_inc;

	logic             tbl_we, ring_we;
	logic [IDX_W-1:0] tbl_waddr;
	tbl_entry_t       tbl_wdata;
	ring_entry_t      ring_wdata;

	logic             pop, push, take_fresh, retire;
	status_t          sts;
	logic [IDX_W-1:0] gslot;
	logic [GEN_W-1:0] ggen;
	logic [CNT_W-1:0] retired_nxt;
	logic [CMP_W-1:0] gslot_ext, retired_ext;

	always_comb begin
		idx_ext   = CMP_W'(idx_q);
		fresh_ext = CMP_W'(fresh_q);
		in_range  = idx_ext < CMP_FULL;
		// Entries at or above the fresh pointer were never written: zero.
		seen       = idx_ext < fresh_ext;
		entry_live = seen && tbl_rd_q.live;
		entry_gen  = seen ? tbl_rd_q.gen : '0;
		gen_inc    = entry_gen + 1'b1;

		sts        = STS_NOT_VALID;
		gslot      = '0;
		ggen       = '0;
		pop        = 1'b0;
		push       = 1'b0;
		take_fresh = 1'b0;
		retire     = 1'b0;
		tbl_we     = 1'b0;
		tbl_waddr  = idx_ext[IDX_W-1:0];
		tbl_wdata  = '{live: 1'b0, gen: entry_gen};
		ring_wdata = '{slot: idx_ext[IDX_W-1:0], gen: gen_inc};

		unique case (req_q)
			REQ_ALLOC: begin
				if (count_q != '0) begin
					pop    = 1'b1;
					gslot  = ring_rd_q.slot;
					ggen   = ring_rd_q.gen;
					sts    = STS_OK;
					tbl_we = 1'b1;
				end else if (fresh_q < CNT_FULL) begin
					take_fresh = 1'b1;
					gslot      = fresh_q[IDX_W-1:0];
					ggen       = '0;
					sts        = STS_OK;
					tbl_we     = 1'b1;
				end else begin
					sts = STS_EXHAUSTED;
				end
				tbl_waddr = gslot;
				tbl_wdata = '{live: 1'b1, gen: ggen};
			end
			REQ_FREE: begin
				if (!in_range || !entry_live) begin
					sts = STS_FREE_REJECTED;
				end else begin
					sts    = STS_OK;
					tbl_we = 1'b1;
					if (entry_gen == GEN_MAX) begin
						retire    = 1'b1;
						tbl_wdata = '{live: 1'b0, gen: entry_gen};
					end else begin
						push      = 1'b1;
						tbl_wdata = '{live: 1'b0, gen: gen_inc};
					end
				end
			end
			REQ_VALIDATE: begin
				if (in_range && entry_live && (entry_gen == hgen_q))
					sts = STS_OK;
				else
					sts = STS_NOT_VALID;
			end
			default: sts = STS_NOT_VALID;
		endcase

		tbl_we  = tbl_we && cmd.commit;
		ring_we = push && cmd.commit;

		retired_nxt = retired_q + CNT_W'(retire);
		gslot_ext   = CMP_W'(gslot);
		retired_ext = CMP_W'(retired_nxt);
	end

	// Stores: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_waddr] <= tbl_wdata;
		if (cmd.capture)
			tbl_rd_q <= tbl_mem[in_addr];
	end

	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[tail_q] <= ring_wdata;
		if (cmd.capture)
			ring_rd_q <= ring_mem[head_q];
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			idx_q  <= slot_index;
			hgen_q <= handle_generation;
		end
		if (cmd.commit) begin
			status_q      <= sts;
			gslot_q       <= gslot_ext[GRANTED_SLOT_W-1:0];
			ggen_q        <= ggen;
			retired_out_q <= retired_ext[RETIRED_W-1:0];
		end
	end

	// Pointers and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			fresh_q   <= '0;
			retired_q <= '0;
		end else if (cmd.commit) begin
			if (pop)
				head_q <= (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
			if (push)
				tail_q <= (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
			if (pop)
				count_q <= count_q - 1'b1;
			else if (push)
				count_q <= count_q + 1'b1;
			if (take_fresh)
				fresh_q <= fresh_q + 1'b1;
			retired_q <= retired_nxt;
		end
	end

	assign status             = status_q;
	assign granted_slot       = gslot_q;
	assign granted_generation = ggen_q;
	assign retired_total      = retired_out_q;

endmodule

`default_nettype wire

[src/generational_slot_allocator.sv]
// Top level of the generational slot allocator.
`default_nettype none

// Generational slot allocator. Hands out slot indices from a pool of
// SLOT_COUNT slots, each with a 16-bit generation; every request beat
// (allocate, free, validate) yields exactly one result beat. Allocate pops
// recycled slots oldest first, then hands out never-used slots, then reports
// exhausted. Free bumps the generation and queues the slot, or retires it for
// good once the generation has reached 0xFFFF. Validate checks live mark and
// generation. A request is first captured, which launches the registered
// reads of the slot table and the recycle ring, then committed, which
// writes those stores and loads the result register; the stores' reads are
// registered and come before their writes. The result register lets the next
// beat be captured while a result still waits, but commit of that beat holds
// until the output side takes the old one. There is no clearing pass after
// reset: slots at or above the fresh-slot pointer have never been handed out
// and read as dead with generation zero.

module generational_slot_allocator #(
	parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [gsa_pkg::REQ_TYPE_W-1:0]     req_type,
	input  wire logic [gsa_pkg::SLOT_INDEX_W-1:0]   slot_index,
	input  wire logic [gsa_pkg::GEN_W-1:0]          handle_generation,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [gsa_pkg::STATUS_W-1:0]            status,
	output logic [gsa_pkg::GRANTED_SLOT_W-1:0]      granted_slot,
	output logic [gsa_pkg::GEN_W-1:0]               granted_generation,
	output logic [gsa_pkg::RETIRED_W-1:0]           retired_total
);
	import gsa_pkg::*;

	gsa_cmd_t cmd;

	// Sequencer: idle -> exec per request; exec waits while the result
	// register is still full and stalled.
	gsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Slot table ({live, generation}), recycle ring, counters, result beat.
	gsa_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.req_type           (req_type),
		.slot_index         (slot_index),
		.handle_generation  (handle_generation),
		.status             (status),
		.granted_slot       (granted_slot),
		.granted_generation (granted_generation),
		.retired_total      (retired_total)
	);

endmodule

`default_nettype wire
